FILE: rtl/core/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the seeded settings shuffler.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SEED_TWEAK  = 64'h4832_2D53_4554_5449;
  localparam logic [15:0] WINDOW_ID   = 16'h0004;
  localparam logic [31:0] WINDOW_BASE = 32'd65535;
  localparam int          WINDOW_BITS = 22;

  localparam int          CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_SEED  = 2'd1;

  localparam int          BITCNT_W    = 6;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_op_t;

  typedef enum logic [1:0] {
    RD_IM1,
    RD_J,
    RD_K
  } rd_addr_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_IM1,
    WR_J,
    WR_WIN
  } wr_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED,
    ST_SH_CHK,
    ST_DR_ADD,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_MA_MIX,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_FIN,
    ST_MOD,
    ST_SW_RA,
    ST_SW_RB,
    ST_SW_W1,
    ST_SW_W2,
    ST_WN_RD,
    ST_WN_CHK,
    ST_WN_WR,
    ST_EM_RD,
    ST_EM_LD,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic     store;
    logic     seed;
    logic     init_i;
    logic     dec_i;
    logic     inc_k;
    logic     clr_k;
    logic     gen_add;
    mul_op_t  mul_op;
    logic     mul_b;
    logic     mix_mid;
    logic     fin;
    logic     mod_step;
    logic     rd_en;
    rd_addr_t rd_addr;
    wr_sel_t  wr_sel;
    logic     cap_a;
    logic     load_out;
    logic     load_err;
    logic     clr_list;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ovf;
    logic rnd;
    logic i_gt1;
    logic k_last;
    logic win_id;
    logic mod_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/sss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer: load, shuffle, draw, window randomize, emit and error phases.
// ----------------------------------------------------------------------------
module sss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  input  sss_pkg::status_t sts,
  output sss_pkg::cmd_t    cmd,
  output logic             busy
);
  import sss_pkg::*;

  state_t state_r, state_nxt;
  logic   win_r, win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      win_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last) begin
          if (sts.ovf || sts.full) state_nxt = ST_ERR;
          else if (sts.rnd)        state_nxt = ST_SEED;
          else                     state_nxt = ST_EM_RD;
        end
      end
      ST_SEED:   state_nxt = ST_SH_CHK;
      ST_SH_CHK: begin
        win_nxt   = 1'b0;
        state_nxt = sts.i_gt1 ? ST_DR_ADD : ST_WN_RD;
      end
      ST_DR_ADD: state_nxt = ST_MA0;
      ST_MA0:    state_nxt = ST_MA1;
      ST_MA1:    state_nxt = ST_MA2;
      ST_MA2:    state_nxt = ST_MA_MIX;
      ST_MA_MIX: state_nxt = ST_MB0;
      ST_MB0:    state_nxt = ST_MB1;
      ST_MB1:    state_nxt = ST_MB2;
      ST_MB2:    state_nxt = ST_FIN;
      ST_FIN:    state_nxt = win_r ? ST_WN_WR : ST_MOD;
      ST_MOD:    if (sts.mod_done) state_nxt = ST_SW_RA;
      ST_SW_RA:  state_nxt = ST_SW_RB;
      ST_SW_RB:  state_nxt = ST_SW_W1;
      ST_SW_W1:  state_nxt = ST_SW_W2;
      ST_SW_W2:  state_nxt = ST_SH_CHK;
      ST_WN_RD:  state_nxt = ST_WN_CHK;
      ST_WN_CHK: begin
        if (sts.win_id) begin
          win_nxt   = 1'b1;
          state_nxt = ST_DR_ADD;
        end else begin
          state_nxt = sts.k_last ? ST_EM_RD : ST_WN_RD;
        end
      end
      ST_WN_WR:  state_nxt = sts.k_last ? ST_EM_RD : ST_WN_RD;
      ST_EM_RD:  state_nxt = ST_EM_LD;
      ST_EM_LD: begin
        if (sts.out_free) state_nxt = sts.k_last ? ST_IDLE : ST_EM_RD;
      end
      ST_ERR:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.store = in_valid;
      ST_SEED: begin
        cmd.seed   = 1'b1;
        cmd.init_i = 1'b1;
        cmd.clr_k  = 1'b1;
      end
      ST_DR_ADD: cmd.gen_add = 1'b1;
      ST_MA0:    cmd.mul_op  = MUL_LL;
      ST_MA1:    cmd.mul_op  = MUL_LH;
      ST_MA2:    cmd.mul_op  = MUL_HL;
      ST_MA_MIX: cmd.mix_mid = 1'b1;
      ST_MB0: begin
        cmd.mul_op = MUL_LL;
        cmd.mul_b  = 1'b1;
      end
      ST_MB1: begin
        cmd.mul_op = MUL_LH;
        cmd.mul_b  = 1'b1;
      end
      ST_MB2: begin
        cmd.mul_op = MUL_HL;
        cmd.mul_b  = 1'b1;
      end
      ST_FIN:    cmd.fin = 1'b1;
      ST_MOD:    cmd.mod_step = 1'b1;
      ST_SW_RA: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RD_IM1;
      end
      ST_SW_RB: begin
        cmd.cap_a   = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RD_J;
      end
      ST_SW_W1:  cmd.wr_sel = WR_IM1;
      ST_SW_W2: begin
        cmd.wr_sel = WR_J;
        cmd.dec_i  = 1'b1;
      end
      ST_WN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RD_K;
      end
      ST_WN_CHK: begin
        if (!sts.win_id) begin
          cmd.inc_k = !sts.k_last;
          cmd.clr_k = sts.k_last;
        end
      end
      ST_WN_WR: begin
        cmd.wr_sel = WR_WIN;
        cmd.inc_k  = !sts.k_last;
        cmd.clr_k  = sts.k_last;
      end
      ST_EM_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RD_K;
      end
      ST_EM_LD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.inc_k    = !sts.k_last;
          cmd.clr_list = sts.k_last;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          cmd.clr_list = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/sss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_dp
// Datapath: entry store, splitmix64 unit, serial modulo, output register.
// ----------------------------------------------------------------------------
module sss_dp #(
  parameter int MAX_SETTINGS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic [15:0]                   in_setting_id,
  input  logic [31:0]                   in_setting_value,
  input  sss_pkg::cmd_t                 cmd,
  output sss_pkg::status_t              sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_id,
  output logic [31:0]                   out_value,
  output logic                          out_last_out,
  output logic                          out_too_many
);
  import sss_pkg::*;

  localparam int IW = (MAX_SETTINGS > 1) ? $clog2(MAX_SETTINGS) : 1;
  localparam int CW = $clog2(MAX_SETTINGS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SETTINGS);

  logic          rnd_r;
  logic [63:0]   seed_r;
  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] k_r;
  logic [63:0]   gen_r;
  logic [63:0]   mx_r;
  logic [63:0]   acc_r;
  logic [63:0]   z_r;
  logic [CW-1:0] rem_r;
  logic [BITCNT_W-1:0] bitcnt_r;
  entry_t        mem [MAX_SETTINGS];
  entry_t        rd_r;
  entry_t        ta_r;
  logic          out_valid_r, out_valid_nxt;
  entry_t        out_r;
  logic          out_last_r;
  logic          out_err_r;

  logic [63:0]   gen_nxt;
  logic [63:0]   kmul;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [CW:0]   mod_t;
  logic [CW-1:0] im1;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_data;
  logic [31:0]   win_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r  <= 1'b0;
      seed_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RANDOM_MODE) rnd_r  <= cfg_wdata[0];
      if (cfg_index == CFG_SHAPE_SEED)  seed_r <= cfg_wdata;
    end
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      k_r   <= '0;
      i_r   <= '0;
    end else begin
      if (cmd.clr_list) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.store) begin
        if (cnt_r == MAX_C) ovf_r <= 1'b1;
        else                cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clr_k || cmd.clr_list) k_r <= '0;
      else if (cmd.inc_k)            k_r <= k_r + 1'b1;
      if (cmd.init_i)     i_r <= cnt_r;
      else if (cmd.dec_i) i_r <= i_r - 1'b1;
    end
  end

  // splitmix64 draw, low 64 bits of each product built from 32x32 parts
  assign gen_nxt = gen_r + GOLDEN_STEP;
  assign kmul    = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    mul_a = mx_r[31:0];
    mul_b = kmul[31:0];
    case (cmd.mul_op)
      MUL_LH:  mul_b = kmul[63:32];
      MUL_HL:  mul_a = mx_r[63:32];
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign mod_t = {rem_r, z_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cmd.seed) begin
      gen_r <= seed_r ^ SEED_TWEAK;
    end else if (cmd.gen_add) begin
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_add) mx_r <= gen_nxt ^ (gen_nxt >> 30);
    else if (cmd.mix_mid) mx_r <= acc_r ^ (acc_r >> 27);
    case (cmd.mul_op)
      MUL_LL:  acc_r <= prod;
      MUL_LH,
      MUL_HL:  acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      default: ;
    endcase
    if (cmd.fin) begin
      z_r      <= acc_r ^ (acc_r >> 31);
      rem_r    <= '0;
      bitcnt_r <= '1;
    end else if (cmd.mod_step) begin
      // restoring remainder, one bit of the draw per cycle
      z_r      <= {z_r[62:0], 1'b0};
      rem_r    <= (mod_t >= {1'b0, i_r}) ? CW'(mod_t - {1'b0, i_r}) : CW'(mod_t);
      bitcnt_r <= bitcnt_r - 1'b1;
    end
  end

  // entry store: one read and one write port
  assign im1 = i_r - 1'b1;
  assign win_val = WINDOW_BASE + {{(32 - WINDOW_BITS){1'b0}}, z_r[WINDOW_BITS-1:0]};

  always_comb begin
    case (cmd.rd_addr)
      RD_IM1:  rd_idx = im1[IW-1:0];
      RD_J:    rd_idx = rem_r[IW-1:0];
      default: rd_idx = k_r[IW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cnt_r[IW-1:0];
    wr_data = '{id: in_setting_id, value: in_setting_value};
    case (cmd.wr_sel)
      WR_IM1: begin
        wr_en   = 1'b1;
        wr_idx  = im1[IW-1:0];
        wr_data = rd_r;
      end
      WR_J: begin
        wr_en   = 1'b1;
        wr_idx  = rem_r[IW-1:0];
        wr_data = ta_r;
      end
      WR_WIN: begin
        wr_en   = 1'b1;
        wr_idx  = k_r[IW-1:0];
        wr_data = '{id: rd_r.id, value: win_val};
      end
      default: wr_en = cmd.store && (cnt_r != MAX_C);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (cmd.rd_en) rd_r <= mem[rd_idx];
    if (cmd.cap_a) ta_r <= rd_r;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out || cmd.load_err) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_r      <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (cmd.load_out) begin
      out_r      <= rd_r;
      out_last_r <= sts.k_last;
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_id       = out_r.id;
  assign out_value    = out_r.value;
  assign out_last_out = out_last_r;
  assign out_too_many = out_err_r;

  always_comb begin
    sts.full     = (cnt_r == MAX_C);
    sts.ovf      = ovf_r;
    sts.rnd      = rnd_r;
    sts.i_gt1    = (i_r > CW'(1));
    sts.k_last   = ((k_r + 1'b1) == cnt_r);
    sts.win_id   = (rd_r.id == WINDOW_ID);
    sts.mod_done = (bitcnt_r == '0);
    sts.out_free = !out_valid_r || !out_stall;
  end

endmodule

FILE: rtl/core/seeded_settings_shuffler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_settings_shuffler
// Collects a settings list and emits it, optionally shuffled and randomized.
// ----------------------------------------------------------------------------
// Each input item is taken while the block is loading a list; a non-final
// item gives no result. On the final item the block stops taking items and
// works alone until the last result is loaded: pass-through reads and emits
// each entry in turn. Random mode adds a seed step, and for each of the n-1
// shuffle steps a check, a splitmix64 draw built from one shared 32x32
// multiplier, a bit-serial remainder and a swap through the entry store,
// plus a closing check, then a randomize pass that checks each entry and
// gives each window entry a fresh draw and a write-back. Output stall while a
// result is held delays the block. An overlong list returns one error result
// with too_many and last_out set.
module seeded_settings_shuffler #(
  parameter int MAX_SETTINGS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_setting_id,
  input  logic [31:0]                   in_setting_value,
  input  logic                          in_last_setting,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_id,
  output logic [31:0]                   out_value,
  output logic                          out_last_out,
  output logic                          out_too_many
);
  import sss_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    busy;

  assign in_stall = busy;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_setting),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  sss_dp #(
    .MAX_SETTINGS (MAX_SETTINGS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_setting_id    (in_setting_id),
    .in_setting_value (in_setting_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_id           (out_id),
    .out_value        (out_value),
    .out_last_out     (out_last_out),
    .out_too_many     (out_too_many)
  );

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_many |-> out_last_out && out_id == '0 && out_value == '0)
    else $error("error result not in canonical form");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out || cmd.load_err) |-> sts.out_free)
    else $error("output register overwritten while held");

  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !busy)
    else $error("entry stored outside load phase");

endmodule
